// ----- hdl/tms_pkg.sv -----
// Package for the transform matrix stack: sizes, codes, state and command types.
// Used by tms_datapath, tms_controller, the top level and the testbench; depends on nothing.
`default_nettype none

package tms_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int ENT_W       = $clog2(STACK_DEPTH);
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int MAT_WORDS   = 16;
  localparam int ADDR_W      = 1 + ENT_W + 4;
  localparam int RAM_DEPTH   = 2 ** ADDR_W;

  localparam int ELEM_W = 32;
  localparam int FRAC_W = 16;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int HEAD_W = ACC_W - ELEM_W - FRAC_W + 1;

  localparam logic [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W - 1){1'b1}}};
  localparam logic [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W - 1){1'b0}}};

  localparam int DEPTH_W       = 5;
  localparam int IN_TDATA_W    = 136;
  localparam int IN_TUSER_W    = 3;
  localparam int OUT_TDATA_W   = 136;
  localparam int OUT_TUSER_W   = 2;
  localparam int ROW_W         = 2;
  localparam int ELEMS_LSB     = ROW_W;
  localparam int OUT_DEPTH_LSB = ROW_W + 4 * ELEM_W;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_ACC,
    S_SAT,
    S_COPY,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic                 stage_we;
    logic                 rd_issue;
    logic                 mul_en;
    logic                 acc_en;
    logic                 sat_wr;
    logic                 copy_wr;
    logic                 row_ld;
    logic                 info_ld;
    status_t              status;
    logic [DEPTH_W-1:0]   depth;
    logic                 last;
    logic                 sel;
    logic [ENT_W-1:0]     ent;
    logic [1:0]           row;
    logic [1:0]           col;
    logic [1:0]           term;
  } tms_cmd_t;

endpackage

`default_nettype wire

// ----- hdl/tms_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module tms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- hdl/tms_datapath.sv -----
// Datapath: row staging, stack memory, shared multiply-accumulate and output beat registers.
// Depends on tms_pkg and tms_ram; driven by tms_controller through tms_cmd_t.
`default_nettype none

module tms_datapath
  import tms_pkg::*;
(
  input  logic                  clk,
  input  tms_cmd_t              cmd,
  input  logic [1:0]            in_row_index,
  input  logic [4*ELEM_W-1:0]   in_elems,
  output status_t               out_status,
  output logic [1:0]            out_row,
  output logic [4*ELEM_W-1:0]   out_elems,
  output logic [DEPTH_W-1:0]    out_depth,
  output logic                  out_last
);

  logic [ELEM_W-1:0]        stage_r [MAT_WORDS];
  logic [ELEM_W-1:0]        b_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic [ELEM_W-1:0]        col_r [4];
  status_t                  status_r;
  logic [1:0]               row_r;
  logic [DEPTH_W-1:0]       depth_r;
  logic                     last_r;

  logic [ELEM_W-1:0] sat_val;
  logic [ELEM_W-1:0] copy_val;
  logic              ram_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [ELEM_W-1:0] wr_data;
  logic [ELEM_W-1:0] rd_data;

  assign rd_addr  = {cmd.sel, ENT_W'(cmd.ent - 1'b1), cmd.row, cmd.term};
  assign wr_addr  = {cmd.sel, cmd.ent, cmd.row, cmd.col};
  assign copy_val = stage_r[{cmd.row, cmd.col}];
  assign ram_we   = cmd.sat_wr | cmd.copy_wr;
  assign wr_data  = cmd.sat_wr ? sat_val : copy_val;

  tms_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (RAM_DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    acc_nxt = ((cmd.term == 2'd0) ? '0 : acc_r)
              + {{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
  end

  // The sum is floored by dropping the low FRAC_W bits; it fits when the top bits are all sign.
  always_comb begin
    if (acc_r[ACC_W-1:ELEM_W+FRAC_W-1] == {HEAD_W{acc_r[ACC_W-1]}}) begin
      sat_val = acc_r[ELEM_W+FRAC_W-1:FRAC_W];
    end else if (acc_r[ACC_W-1]) begin
      sat_val = ELEM_MIN;
    end else begin
      sat_val = ELEM_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.stage_we) begin
      for (int j = 0; j < 4; j++) begin
        stage_r[{in_row_index, 2'(j)}] <= in_elems[j*ELEM_W +: ELEM_W];
      end
    end
    if (cmd.rd_issue) begin
      b_r <= stage_r[{cmd.term, cmd.col}];
    end
    if (cmd.mul_en) begin
      prod_r <= $signed(rd_data) * $signed(b_r);
    end
    if (cmd.acc_en) begin
      acc_r <= acc_nxt;
    end
    if (cmd.sat_wr) begin
      col_r[cmd.col] <= sat_val;
    end else if (cmd.copy_wr) begin
      col_r[cmd.col] <= copy_val;
    end else if (cmd.info_ld) begin
      for (int j = 0; j < 4; j++) begin
        col_r[j] <= '0;
      end
    end
    if (cmd.row_ld || cmd.info_ld) begin
      status_r <= cmd.status;
      depth_r  <= cmd.depth;
      last_r   <= cmd.last;
      row_r    <= cmd.info_ld ? 2'd0 : cmd.row;
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      out_elems[j*ELEM_W +: ELEM_W] = col_r[j];
    end
  end

  assign out_status = status_r;
  assign out_row    = row_r;
  assign out_depth  = depth_r;
  assign out_last   = last_r;

endmodule

`default_nettype wire

// ----- hdl/tms_controller.sv -----
// Controller: stack levels, operation decode and the sequencer for the matrix product.
// Depends on tms_pkg; commands tms_datapath through tms_cmd_t.
`default_nettype none

module tms_controller
  import tms_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [1:0] in_func,
  input  logic       in_sel,
  input  logic [1:0] in_row_index,
  output logic       out_tvalid,
  input  logic       out_tready,
  output tms_cmd_t   cmd
);

  state_t             state_r, state_nxt;
  logic [LVL_W-1:0]   lvl_r [2];
  logic [LVL_W-1:0]   lvl_nxt [2];
  logic               sel_r, sel_nxt;
  logic [ENT_W-1:0]   ent_r, ent_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic               copy_r, copy_nxt;
  logic               info_r, info_nxt;
  logic [1:0]         row_cnt_r, row_cnt_nxt;
  logic [1:0]         col_cnt_r, col_cnt_nxt;
  logic [1:0]         term_cnt_r, term_cnt_nxt;
  logic [LVL_W-1:0]   cur_lvl;

  assign cur_lvl = lvl_r[in_sel];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      lvl_r[0]   <= '0;
      lvl_r[1]   <= '0;
      sel_r      <= 1'b0;
      ent_r      <= '0;
      depth_r    <= '0;
      copy_r     <= 1'b0;
      info_r     <= 1'b0;
      row_cnt_r  <= '0;
      col_cnt_r  <= '0;
      term_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      lvl_r[0]   <= lvl_nxt[0];
      lvl_r[1]   <= lvl_nxt[1];
      sel_r      <= sel_nxt;
      ent_r      <= ent_nxt;
      depth_r    <= depth_nxt;
      copy_r     <= copy_nxt;
      info_r     <= info_nxt;
      row_cnt_r  <= row_cnt_nxt;
      col_cnt_r  <= col_cnt_nxt;
      term_cnt_r <= term_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    lvl_nxt[0]   = lvl_r[0];
    lvl_nxt[1]   = lvl_r[1];
    sel_nxt      = sel_r;
    ent_nxt      = ent_r;
    depth_nxt    = depth_r;
    copy_nxt     = copy_r;
    info_nxt     = info_r;
    row_cnt_nxt  = row_cnt_r;
    col_cnt_nxt  = col_cnt_r;
    term_cnt_nxt = term_cnt_r;
    in_tready    = 1'b0;
    out_tvalid   = 1'b0;

    cmd        = '0;
    cmd.status = ST_OK;
    cmd.depth  = depth_r;
    cmd.sel    = sel_r;
    cmd.ent    = ent_r;
    cmd.row    = row_cnt_r;
    cmd.col    = col_cnt_r;
    cmd.term   = term_cnt_r;
    cmd.last   = (row_cnt_r == 2'd3);

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          sel_nxt = in_sel;
          case (in_func)
            FUNC_CLEAR: begin
              lvl_nxt[0]  = '0;
              lvl_nxt[1]  = '0;
              cmd.info_ld = 1'b1;
              cmd.status  = ST_OK;
              cmd.depth   = '0;
              cmd.last    = 1'b1;
              info_nxt    = 1'b1;
              state_nxt   = S_EMIT;
            end
            FUNC_POP: begin
              cmd.info_ld = 1'b1;
              cmd.last    = 1'b1;
              info_nxt    = 1'b1;
              state_nxt   = S_EMIT;
              if (cur_lvl < LVL_W'(2)) begin
                cmd.status = ST_UNDERFLOW;
                cmd.depth  = DEPTH_W'(cur_lvl);
              end else begin
                lvl_nxt[in_sel] = cur_lvl - 1'b1;
                cmd.status      = ST_OK;
                cmd.depth       = DEPTH_W'(cur_lvl - 1'b1);
              end
            end
            FUNC_PUSH: begin
              cmd.stage_we = 1'b1;
              if (in_row_index == 2'd3) begin
                if (cur_lvl >= LVL_W'(STACK_DEPTH)) begin
                  cmd.info_ld = 1'b1;
                  cmd.status  = ST_OVERFLOW;
                  cmd.depth   = DEPTH_W'(cur_lvl);
                  cmd.last    = 1'b1;
                  info_nxt    = 1'b1;
                  state_nxt   = S_EMIT;
                end else begin
                  lvl_nxt[in_sel] = cur_lvl + 1'b1;
                  ent_nxt         = cur_lvl[ENT_W-1:0];
                  depth_nxt       = DEPTH_W'(cur_lvl + 1'b1);
                  copy_nxt        = (cur_lvl == '0);
                  info_nxt        = 1'b0;
                  row_cnt_nxt     = '0;
                  col_cnt_nxt     = '0;
                  term_cnt_nxt    = '0;
                  state_nxt       = (cur_lvl == '0) ? S_COPY : S_LOAD;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LOAD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        if (term_cnt_r == 2'd3) begin
          term_cnt_nxt = '0;
          state_nxt    = S_SAT;
        end else begin
          term_cnt_nxt = term_cnt_r + 1'b1;
          state_nxt    = S_LOAD;
        end
      end
      S_SAT: begin
        cmd.sat_wr = 1'b1;
        if (col_cnt_r == 2'd3) begin
          cmd.row_ld = 1'b1;
          state_nxt  = S_EMIT;
        end else begin
          col_cnt_nxt = col_cnt_r + 1'b1;
          state_nxt   = S_LOAD;
        end
      end
      S_COPY: begin
        cmd.copy_wr = 1'b1;
        if (col_cnt_r == 2'd3) begin
          cmd.row_ld = 1'b1;
          state_nxt  = S_EMIT;
        end else begin
          col_cnt_nxt = col_cnt_r + 1'b1;
        end
      end
      S_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (info_r || row_cnt_r == 2'd3) begin
            state_nxt = S_IDLE;
          end else begin
            row_cnt_nxt  = row_cnt_r + 1'b1;
            col_cnt_nxt  = '0;
            term_cnt_nxt = '0;
            state_nxt    = copy_r ? S_COPY : S_LOAD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/transform_matrix_stack.sv -----
// Top level of the transform matrix stack: stream ports, controller and datapath.
// Depends on tms_pkg, tms_controller and tms_datapath.
// Push rows 0 to 2 are staged and give no beat. Pop, clear and overflow
// give one beat, valid the cycle after acceptance. A push onto an empty stack copies
// each row into memory and shows it only after the previous beat is taken; otherwise
// each element is summed over four terms (load, multiply, accumulate) and then saturated
// on the one shared multiplier-accumulator fed by the single stack memory read port.
// in_tready is high only while idle. Reset empties both stacks; memory is not cleared.
`default_nettype none

module transform_matrix_stack
  import tms_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // row_index [1:0], elem_col0 [33:2], elem_col1 [65:34], elem_col2 [97:66],
  // elem_col3 [129:98], zero fill above.
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // func [1:0], stack_select [2].
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_row [1:0], out_col0 [33:2], out_col1 [65:34], out_col2 [97:66],
  // out_col3 [129:98], depth_after [134:130], zero fill above.
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // status [1:0].
  output logic [OUT_TUSER_W-1:0] out_tuser,
  output logic                   out_tlast
);

  tms_cmd_t            cmd;
  status_t             dp_status;
  logic [1:0]          dp_row;
  logic [4*ELEM_W-1:0] dp_elems;
  logic [DEPTH_W-1:0]  dp_depth;
  logic                dp_last;

  tms_controller u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_func      (in_tuser[1:0]),
    .in_sel       (in_tuser[2]),
    .in_row_index (in_tdata[ROW_W-1:0]),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .cmd          (cmd)
  );

  tms_datapath u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .in_row_index (in_tdata[ROW_W-1:0]),
    .in_elems     (in_tdata[ELEMS_LSB +: 4*ELEM_W]),
    .out_status   (dp_status),
    .out_row      (dp_row),
    .out_elems    (dp_elems),
    .out_depth    (dp_depth),
    .out_last     (dp_last)
  );

  assign out_tdata = {{(OUT_TDATA_W - OUT_DEPTH_LSB - DEPTH_W){1'b0}},
                      dp_depth, dp_elems, dp_row};
  assign out_tuser = dp_status;
  assign out_tlast = dp_last;

  localparam logic [DEPTH_W-1:0] FULL_DEPTH = DEPTH_W'(STACK_DEPTH);

  a_one_side_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while a beat is pending");

  a_error_beat_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tlast && out_tdata[OUT_DEPTH_LSB-1:0] == '0)
    else $error("error beat carries row data or is not last");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_OVERFLOW |->
      out_tdata[OUT_DEPTH_LSB +: DEPTH_W] == FULL_DEPTH)
    else $error("overflow reported on a stack that is not full");

  a_underflow_shallow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_UNDERFLOW |->
      out_tdata[OUT_DEPTH_LSB +: DEPTH_W] < DEPTH_W'(2))
    else $error("underflow reported with two or more entries");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for transform_matrix_stack: directed table, then random matrix stack
// traffic with random stalls on both stream sides, checked beat by beat against a predictor.
// Depends on tms_pkg and the transform_matrix_stack RTL.
module tb_top;
  import tms_pkg::*;

  localparam int          RANDOM_ITEMS = 205;
  localparam int          QUIET_ITEMS  = 30;
  localparam int          LONG_HOLD    = 400;
  localparam int          TAIL_CYCLES  = 250;
  localparam int          CYCLE_LIMIT  = 500000;
  localparam int          DIR_ROWS     = 21;
  localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
  localparam logic [31:0] Q_ONE        = 32'h0001_0000;
  localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;

  typedef logic [0:3][31:0] quad_t;

  typedef struct packed {
    logic [1:0] func;
    logic       sel;
    logic [1:0] row;
    quad_t      col;
  } stack_cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] row;
    quad_t      col;
    logic [4:0] depth;
    logic       last;
  } row_beat_t;

  typedef struct packed {
    stack_cmd_t cmd;
    logic       typed;
    logic [1:0] status;
    logic [4:0] depth;
  } dir_row_t;

  localparam quad_t ZERO4 = '{32'h0, 32'h0, 32'h0, 32'h0};

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;

  quad_t       stack_mem [2][STACK_DEPTH][4];
  int unsigned level [2];
  quad_t       staging [3];
  row_beat_t   pending_beats [$];

  int  errors;
  int  cycles;
  int  n_items;
  int  n_beats;
  int  n_push_done;
  int  n_overflow;
  int  n_underflow;
  int  n_pop_ok;
  int  n_clear;
  bit  quiet;
  bit  hold_req;
  bit  hold_done;
  int  hold_left;
  int  stall_left;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{'{FUNC_POP,   1'b0, 2'd0, ZERO4}, 1'b1, ST_UNDERFLOW, 5'd0},
    '{'{FUNC_POP,   1'b1, 2'd0, ZERO4}, 1'b1, ST_UNDERFLOW, 5'd0},
    '{'{FUNC_PUSH,  1'b0, 2'd0, '{ELEM_MAX, ELEM_MIN, 32'h0, ALL_ONES}}, 1'b0, ST_OK, 5'd0},
    '{'{FUNC_PUSH,  1'b0, 2'd1, '{ELEM_MIN, ELEM_MAX, Q_ONE, 32'h0}}, 1'b0, ST_OK, 5'd0},
    '{'{FUNC_PUSH,  1'b0, 2'd2, '{Q_ONE, ALL_ONES, ELEM_MAX, ELEM_MIN}}, 1'b0, ST_OK, 5'd0},
    '{'{FUNC_PUSH,  1'b0, 2'd3, '{32'h0, Q_ONE, ELEM_MIN, ELEM_MAX}}, 1'b0, ST_OK, 5'd0},
    '{'{FUNC_PUSH,  1'b0, 2'd0, '{ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX}}, 1'b0, ST_OK, 5'd0},
    '{'{FUNC_PUSH,  1'b0, 2'd1, '{ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX}}, 1'b0, ST_OK, 5'd0},
    '{'{FUNC_PUSH,  1'b0, 2'd2, '{ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN}}, 1'b0, ST_OK, 5'd0},
    '{'{FUNC_PUSH,  1'b0, 2'd3, '{ELEM_MIN, ELEM_MAX, Q_ONE, ALL_ONES}}, 1'b0, ST_OK, 5'd0},
    '{'{FUNC_POP,   1'b0, 2'd0, ZERO4}, 1'b1, ST_OK, 5'd1},
    '{'{FUNC_POP,   1'b0, 2'd0, ZERO4}, 1'b1, ST_UNDERFLOW, 5'd1},
    '{'{FUNC_UNUSED, 1'b1, 2'd3, '{ELEM_MAX, ELEM_MIN, ALL_ONES, Q_ONE}}, 1'b0, ST_OK, 5'd0},
    '{'{FUNC_PUSH,  1'b0, 2'd0, '{Q_ONE, 32'h0, 32'h0, 32'h0}}, 1'b0, ST_OK, 5'd0},
    '{'{FUNC_PUSH,  1'b1, 2'd1, '{32'h0, Q_ONE, 32'h0, 32'h0}}, 1'b0, ST_OK, 5'd0},
    '{'{FUNC_PUSH,  1'b0, 2'd2, '{32'h0, 32'h0, Q_ONE, 32'h0}}, 1'b0, ST_OK, 5'd0},
    '{'{FUNC_PUSH,  1'b1, 2'd3, '{32'h0, 32'h0, 32'h0, Q_ONE}}, 1'b0, ST_OK, 5'd0},
    '{'{FUNC_PUSH,  1'b1, 2'd3, '{32'h0002_0000, 32'hFFFF_8000, Q_ONE, 32'h1}}, 1'b0, ST_OK,
      5'd0},
    '{'{FUNC_CLEAR, 1'b0, 2'd0, ZERO4}, 1'b1, ST_OK, 5'd0},
    '{'{FUNC_POP,   1'b1, 2'd0, ZERO4}, 1'b1, ST_UNDERFLOW, 5'd0},
    '{'{FUNC_PUSH,  1'b0, 2'd3, '{Q_ONE, ELEM_MIN, ELEM_MAX, 32'h0}}, 1'b0, ST_OK, 5'd0}
  };

  transform_matrix_stack u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // One element of a product: exact sum of four Q32.32 products, floored to Q16.16, saturated.
  function automatic logic [31:0] q16_dot(quad_t a, quad_t b);
    logic signed [65:0] acc;
    logic signed [65:0] scaled;
    int                 k;
    acc = '0;
    for (k = 0; k < 4; k++) begin
      acc += 66'(signed'(a[k])) * 66'(signed'(b[k]));
    end
    scaled = acc >>> FRAC_W;
    if (scaled > 66'sh7FFF_FFFF) return ELEM_MAX;
    if (scaled < -66'sh8000_0000) return ELEM_MIN;
    return scaled[31:0];
  endfunction

  // Updates the stack state for one accepted beat and queues the result beats it causes.
  function automatic void stack_predict(stack_cmd_t c);
    row_beat_t   b;
    quad_t       inc [4];
    quad_t       top [4];
    quad_t       col_vec;
    int unsigned lv;
    int          r;
    int          j;
    int          k;
    b      = '0;
    b.last = 1'b1;
    lv     = level[c.sel];
    case (c.func)
      FUNC_CLEAR: begin
        level[0] = 0;
        level[1] = 0;
        n_clear++;
        pending_beats.push_back(b);
      end
      FUNC_POP: begin
        if (lv < 2) begin
          b.status = ST_UNDERFLOW;
          n_underflow++;
        end else begin
          lv--;
          level[c.sel] = lv;
          n_pop_ok++;
        end
        b.depth = 5'(lv);
        pending_beats.push_back(b);
      end
      FUNC_PUSH: begin
        if (c.row < 2'd3) begin
          staging[c.row] = c.col;
        end else if (lv >= STACK_DEPTH) begin
          b.status = ST_OVERFLOW;
          b.depth  = 5'(lv);
          n_overflow++;
          pending_beats.push_back(b);
        end else begin
          for (r = 0; r < 3; r++) inc[r] = staging[r];
          inc[3] = c.col;
          for (r = 0; r < 4; r++) begin
            if (lv == 0) begin
              top[r] = inc[r];
            end else begin
              for (j = 0; j < 4; j++) begin
                for (k = 0; k < 4; k++) col_vec[k] = inc[k][j];
                top[r][j] = q16_dot(stack_mem[c.sel][lv-1][r], col_vec);
              end
            end
            stack_mem[c.sel][lv][r] = top[r];
          end
          level[c.sel] = lv + 1;
          n_push_done++;
          for (r = 0; r < 4; r++) begin
            b.row   = 2'(r);
            b.col   = top[r];
            b.depth = 5'(lv + 1);
            b.last  = (r == 3);
            pending_beats.push_back(b);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [31:0] elem_value();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
    if (pick < 70) return $urandom;
    if (pick < 85) begin
      case ($urandom_range(0, 5))
        0: return ELEM_MAX;
        1: return ELEM_MIN;
        2: return 32'h0;
        3: return ALL_ONES;
        4: return 32'h1;
        default: return Q_ONE;
      endcase
    end
    return $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
  endfunction

  function automatic stack_cmd_t make_cmd(logic [1:0] func, logic sel, logic [1:0] row);
    stack_cmd_t c;
    int         k;
    c.func = func;
    c.sel  = sel;
    c.row  = row;
    for (k = 0; k < 4; k++) c.col[k] = elem_value();
    return c;
  endfunction

  task automatic send_cmd(stack_cmd_t c);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, c.col[3], c.col[2], c.col[1], c.col[0], c.row};
    in_tuser  <= {c.sel, c.func};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    stack_predict(c);
    if (c.func != FUNC_UNUSED) n_items++;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d beats outstanding.", cycles,
               pending_beats.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random short stalls, plus one long hold counted here to back up the block.
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : beat_check
    row_beat_t got;
    row_beat_t want;
    int        k;
    if (rst_n && out_tvalid && out_tready) begin
      n_beats++;
      got.status = out_tuser[1:0];
      got.row    = out_tdata[1:0];
      for (k = 0; k < 4; k++) got.col[k] = out_tdata[ELEMS_LSB + ELEM_W*k +: ELEM_W];
      got.depth = out_tdata[OUT_DEPTH_LSB +: DEPTH_W];
      got.last  = out_tlast;
      if (pending_beats.size() == 0) begin
        $error("Result beat with nothing expected: status %0d row %0d depth %0d",
               got.status, got.row, got.depth);
        errors++;
      end else begin
        want = pending_beats.pop_front();
        if (got.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
        if (got.row != want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, got.row);
          errors++;
        end
        for (k = 0; k < 4; k++) begin
          if (got.col[k] != want.col[k]) begin
            $error("out_col%0d: expected %h, got %h", k, want.col[k], got.col[k]);
            errors++;
          end
        end
        if (got.depth != want.depth) begin
          $error("depth_after: expected %0d, got %0d", want.depth, got.depth);
          errors++;
        end
        if (got.last != want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last);
          errors++;
        end
      end
    end
  end

  initial begin
    row_beat_t  typed_beat;
    int         i;
    int         n;
    logic       s;
    int         base;
    int         pick;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    out_tready <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < DIR_ROWS; i++) begin
      send_cmd(dir_tab[i].cmd);
      if (dir_tab[i].typed) begin
        typed_beat        = '0;
        typed_beat.status = dir_tab[i].status;
        typed_beat.depth  = dir_tab[i].depth;
        typed_beat.last   = 1'b1;
        pending_beats[pending_beats.size()-1] = typed_beat;
      end
    end

    base = n_items;
    while (n_items - base < RANDOM_ITEMS) begin
      if (n_items - base >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      if (n_items - base >= 80) hold_req = 1'b1;
      pick = $urandom_range(0, 99);
      s    = 1'($urandom_range(0, 1));
      if (pick < 45) begin
        for (i = 0; i < 4; i++) begin
          send_cmd(make_cmd(FUNC_PUSH, (i == 3) ? s : 1'($urandom_range(0, 1)), 2'(i)));
        end
      end else if (pick < 60) begin
        send_cmd(make_cmd(FUNC_PUSH, s, 2'd3));
      end else if (pick < 75) begin
        send_cmd(make_cmd(FUNC_POP, s, 2'($urandom_range(0, 3))));
      end else if (pick < 80) begin
        send_cmd(make_cmd(FUNC_CLEAR, s, 2'($urandom_range(0, 3))));
      end else if (pick < 85) begin
        send_cmd(make_cmd(FUNC_UNUSED, s, 2'($urandom_range(0, 3))));
      end else if (pick < 90) begin
        send_cmd(make_cmd(FUNC_PUSH, s, 2'($urandom_range(0, 2))));
      end else if (pick < 95) begin
        // Fill the chosen stack past full so the overflow path is taken.
        n = STACK_DEPTH - level[s] + 1 + $urandom_range(0, 1);
        for (i = 0; i < n; i++) send_cmd(make_cmd(FUNC_PUSH, s, 2'd3));
      end else begin
        n = $urandom_range(2, 8);
        for (i = 0; i < n; i++) send_cmd(make_cmd(FUNC_POP, s, 2'd0));
      end
    end
    in_tvalid <= 1'b0;

    while (pending_beats.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d input beats and %0d result beats in %0d cycles.", n_items, n_beats,
             cycles);
    $display("Pushes %0d, overflows %0d, pops %0d, underflows %0d, clears %0d; %0d errors.",
             n_push_done, n_overflow, n_pop_ok, n_underflow, n_clear, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/tms_pkg.sv
hdl/tms_ram.sv
hdl/tms_datapath.sv
hdl/tms_controller.sv
hdl/transform_matrix_stack.sv
test/tb_top.sv
